// ===== design/multichannel_ring_modulator_macros.svh =====
// ----------------------------------------------------------------------------
// Multichannel ring modulator assertion macros
// Shared concurrent assertion forms, clocked on aclk, quiet during reset.
// ----------------------------------------------------------------------------
`ifndef MULTICHANNEL_RING_MODULATOR_MACROS_SVH
`define MULTICHANNEL_RING_MODULATOR_MACROS_SVH

// Check a consequence in the same cycle as its cause
`define MRM_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Check a consequence in the cycle after its cause
`define MRM_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== design/mrm_pkg.sv =====
// ----------------------------------------------------------------------------
// Multichannel ring modulator package
// Widths, operation codes and the quarter-wave sine table generator.
// ----------------------------------------------------------------------------
package mrm_pkg;

    // Channel state
    localparam int CHANNELS   = 8;
    localparam int CHAN_IDX_W = $clog2(CHANNELS);
    localparam int PHASE_W    = 32;
    localparam logic [PHASE_W-1:0] INC_RESET = 32'd389566;

    // Field widths
    localparam int OP_W        = 2;
    localparam int CHAN_W      = 3;
    localparam int SAMPLE_BITS = 24;
    localparam int S_FIELDS_W  = CHAN_W + 2 * SAMPLE_BITS + 1 + PHASE_W;
    localparam int S_TDATA_W   = ((S_FIELDS_W + 7) / 8) * 8;
    localparam int M_TDATA_W   = ((SAMPLE_BITS + 7) / 8) * 8;

    // Sine table: quarter wave, entries in units of 2^-23
    localparam int SINE_ADDR_BITS = 10;
    localparam int QUARTER_LEN    = 1 << SINE_ADDR_BITS;
    localparam int ROM_AW         = SINE_ADDR_BITS + 1;
    localparam int SINE_W         = 24;
    localparam logic [63:0] ONE_Q23     = 64'd1 << 23;
    localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;
    localparam logic [63:0] TAYLOR_DIV [8] = '{64'd6, 64'd20, 64'd42, 64'd72,
                                               64'd110, 64'd156, 64'd210, 64'd272};

    // Item kinds carried in tuser
    typedef enum logic [OP_W-1:0] {
        OP_SAMPLE    = 2'd0,
        OP_LOAD_INC  = 2'd1,
        OP_CLEAR_ALL = 2'd2
    } op_t;

    typedef logic [SINE_W-1:0] sine_rom_t [QUARTER_LEN + 1];

    // Taylor series sine of k quarter-wave steps, Q30 worked, Q23 result
    function automatic logic [SINE_W-1:0] quarter_sine(input int unsigned k);
        logic [63:0] theta;
        logic [63:0] theta2;
        logic [63:0] term;
        logic [63:0] sum;
        int          n;
        theta  = (64'(k) * HALF_PI_Q30) >> SINE_ADDR_BITS;
        theta2 = (theta * theta) >> 30;
        term   = theta;
        sum    = theta;
        for (n = 0; n < 8; n++) begin
            term = ((term * theta2) >> 30) / TAYLOR_DIV[n];
            if (n[0] == 1'b0) begin
                sum = sum - term;
            end else begin
                sum = sum + term;
            end
        end
        sum = (sum + 64'd64) >> 7;
        if (sum > ONE_Q23) begin
            sum = ONE_Q23;
        end
        return sum[SINE_W-1:0];
    endfunction

    // Whole quarter-wave table, both ends included
    function automatic sine_rom_t build_sine_rom();
        sine_rom_t rom;
        int        k;
        for (k = 0; k <= QUARTER_LEN; k++) begin
            rom[k] = quarter_sine(k);
        end
        return rom;
    endfunction

endpackage

// ===== design/mrm_sine_rom.sv =====
// ----------------------------------------------------------------------------
// Quarter-wave sine ROM
// Constant table of sine magnitudes with a registered read port.
// ----------------------------------------------------------------------------
module mrm_sine_rom
    import mrm_pkg::*;
(
    input  logic              aclk,
    input  logic              rd_en,
    input  logic [ROM_AW-1:0] rd_addr,
    output logic [SINE_W-1:0] rd_data
);

    localparam sine_rom_t SINE_TABLE = build_sine_rom();

    logic [SINE_W-1:0] rd_data_reg;

    // Read one entry when the stage advances
    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data_reg <= SINE_TABLE[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== design/multichannel_ring_modulator.sv =====
// ----------------------------------------------------------------------------
// Multichannel ring modulator
// Eight oscillators, each multiplying its channel's samples by a sine and adding a prior sample or not.
// ----------------------------------------------------------------------------
// Input stream (s_): one transaction per item. tuser holds the kind: a sample,
// a load of one channel's increment (its phase cleared too), or a clear of all
// phases. Only sample transactions give a result on the output stream (m_).
// cfg_wen/cfg_wdata write the enable bit; with it low, samples pass unchanged
// and no phase moves. Write it only while the block is empty.
// An accepted sample passes in order through a five-register chain (input, sine
// address, ROM read, product, output) to m_tvalid. Throughput: one transaction
// per cycle, sustained while m_tready stays high.
// Phase state is updated as an item leaves the input register, so items of
// the same channel may follow one another in consecutive cycles.
// Stall: a held result blocks only its own register; empty stages keep
// filling, and s_tready falls once all five hold items.
// Reset: phases clear to zero, increments return to 389566 (4 Hz at 44.1 kHz),
// the enable bit sets and all stages empty.
// ----------------------------------------------------------------------------
module multichannel_ring_modulator
    import mrm_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    // Configuration
    input  logic                 cfg_wen,
    input  logic                 cfg_wdata,
    // Input stream
    input  logic                 s_tvalid,
    output logic                 s_tready,
    // channel[2:0], sample[26:3], prior[50:27], replace[51], increment[83:52], zero pad
    input  logic [S_TDATA_W-1:0] s_tdata,
    // op[1:0]
    input  logic [OP_W-1:0]      s_tuser,
    // Result stream
    output logic                 m_tvalid,
    input  logic                 m_tready,
    // out_sample[23:0]
    output logic [M_TDATA_W-1:0] m_tdata
);

    `include "multichannel_ring_modulator_macros.svh"

    localparam int SUM_W = SAMPLE_BITS + 2;
    localparam int PROD_W = SAMPLE_BITS + SINE_W;

    // Channel state and enable
    logic [CHANNELS-1:0][PHASE_W-1:0] phase_reg;
    logic [CHANNELS-1:0][PHASE_W-1:0] inc_reg;
    logic                             enabled_reg;

    // Stage valids and load enables
    logic s1_valid_reg, s2_valid_reg, s3_valid_reg, s4_valid_reg, m_valid_reg;
    logic ld1, ld2, ld3, ld4, ld_out;
    logic s_fire, s1_leave;

    // Stage 1: input register
    logic [OP_W-1:0]               s1_op_reg;
    logic [CHAN_W-1:0]             s1_chan_reg;
    logic signed [SAMPLE_BITS-1:0] s1_sample_reg;
    logic signed [SAMPLE_BITS-1:0] s1_prior_reg;
    logic                          s1_replace_reg;
    logic [PHASE_W-1:0]            s1_inc_reg;

    // Stage 2: sine address
    logic [ROM_AW-1:0]             s2_addr_reg;
    logic                          s2_neg_reg;
    logic                          s2_pass_reg;
    logic [SAMPLE_BITS-1:0]        s2_abs_reg;
    logic signed [SAMPLE_BITS-1:0] s2_sample_reg;
    logic signed [SAMPLE_BITS-1:0] s2_prior_reg;
    logic                          s2_replace_reg;

    // Stage 3: sine magnitude read
    logic [SINE_W-1:0]             rom_data;
    logic                          s3_neg_reg;
    logic                          s3_pass_reg;
    logic [SAMPLE_BITS-1:0]        s3_abs_reg;
    logic signed [SAMPLE_BITS-1:0] s3_sample_reg;
    logic signed [SAMPLE_BITS-1:0] s3_prior_reg;
    logic                          s3_replace_reg;

    // Stage 4: product
    logic [PROD_W-1:0]             s4_prod_reg;
    logic                          s4_neg_reg;
    logic                          s4_pass_reg;
    logic signed [SAMPLE_BITS-1:0] s4_sample_reg;
    logic signed [SAMPLE_BITS-1:0] s4_prior_reg;
    logic                          s4_replace_reg;

    // Output register
    logic [SAMPLE_BITS-1:0]        m_sample_reg;

    // Stage 1 combinational terms
    logic [CHAN_IDX_W-1:0] s1_idx;
    logic                  s1_chan_ok;
    logic [PHASE_W-1:0]    phase_next;
    logic [1:0]            s1_quad;
    logic [SINE_ADDR_BITS-1:0] s1_step;
    logic [ROM_AW-1:0]     addr_next;
    logic [SAMPLE_BITS-1:0] abs_next;

    // Stage 4 combinational terms
    logic [PROD_W:0]        rounded;
    logic [SAMPLE_BITS:0]   mag;
    logic signed [SUM_W-1:0] prod_s;
    logic signed [SUM_W-1:0] base_s;
    logic signed [SUM_W-1:0] sum_s;
    logic signed [SUM_W-1:0] max_s;
    logic signed [SUM_W-1:0] min_s;
    logic [SAMPLE_BITS-1:0] out_next;

    // Stage advance: a stage loads when empty or when its contents move on
    assign ld_out   = !m_valid_reg || m_tready;
    assign ld4      = !s4_valid_reg || ld_out;
    assign ld3      = !s3_valid_reg || ld4;
    assign ld2      = !s2_valid_reg || ld3;
    assign ld1      = !s1_valid_reg || ld2;
    assign s_tready = ld1;
    assign s_fire   = s_tvalid && ld1;
    assign s1_leave = s1_valid_reg && ld2;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
            s4_valid_reg <= 1'b0;
            m_valid_reg  <= 1'b0;
        end else begin
            if (ld1) begin
                s1_valid_reg <= s_fire;
            end
            if (ld2) begin
                s2_valid_reg <= s1_valid_reg && (s1_op_reg == OP_SAMPLE);
            end
            if (ld3) begin
                s3_valid_reg <= s2_valid_reg;
            end
            if (ld4) begin
                s4_valid_reg <= s3_valid_reg;
            end
            if (ld_out) begin
                m_valid_reg <= s4_valid_reg;
            end
        end
    end

    // Enable register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            enabled_reg <= 1'b1;
        end else if (cfg_wen) begin
            enabled_reg <= cfg_wdata;
        end
    end

    // Capture the input transaction
    always_ff @(posedge aclk) begin
        if (ld1) begin
            s1_op_reg      <= s_tuser;
            s1_chan_reg    <= s_tdata[CHAN_W-1:0];
            s1_sample_reg  <= s_tdata[CHAN_W +: SAMPLE_BITS];
            s1_prior_reg   <= s_tdata[CHAN_W + SAMPLE_BITS +: SAMPLE_BITS];
            s1_replace_reg <= s_tdata[CHAN_W + 2 * SAMPLE_BITS];
            s1_inc_reg     <= s_tdata[CHAN_W + 2 * SAMPLE_BITS + 1 +: PHASE_W];
        end
    end

    // Advance the phase and form the quarter-wave address
    always_comb begin
        s1_idx     = s1_chan_reg[CHAN_IDX_W-1:0];
        s1_chan_ok = (32'(s1_chan_reg) < CHANNELS);
        phase_next = phase_reg[s1_idx] + inc_reg[s1_idx];
        s1_quad    = phase_next[PHASE_W-1 -: 2];
        s1_step    = phase_next[PHASE_W-3 -: SINE_ADDR_BITS];
        if (s1_quad[0]) begin
            addr_next = ROM_AW'(QUARTER_LEN) - {1'b0, s1_step};
        end else begin
            addr_next = {1'b0, s1_step};
        end
        abs_next = s1_sample_reg[SAMPLE_BITS-1] ? (~s1_sample_reg + 1'b1)
                                                : s1_sample_reg;
    end

    // Update channel state as an item leaves the input register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int c = 0; c < CHANNELS; c++) begin
                phase_reg[c] <= '0;
                inc_reg[c]   <= INC_RESET;
            end
        end else if (s1_leave) begin
            case (s1_op_reg)
                OP_SAMPLE: begin
                    if (enabled_reg && s1_chan_ok) begin
                        phase_reg[s1_idx] <= phase_next;
                    end
                end
                OP_LOAD_INC: begin
                    if (s1_chan_ok) begin
                        inc_reg[s1_idx]   <= s1_inc_reg;
                        phase_reg[s1_idx] <= '0;
                    end
                end
                OP_CLEAR_ALL: begin
                    phase_reg <= '0;
                end
                default: begin
                end
            endcase
        end
    end

    // Stage 2 register
    always_ff @(posedge aclk) begin
        if (ld2) begin
            s2_addr_reg    <= addr_next;
            s2_neg_reg     <= s1_sample_reg[SAMPLE_BITS-1] ^ s1_quad[1];
            s2_pass_reg    <= !enabled_reg || !s1_chan_ok;
            s2_abs_reg     <= abs_next;
            s2_sample_reg  <= s1_sample_reg;
            s2_prior_reg   <= s1_prior_reg;
            s2_replace_reg <= s1_replace_reg;
        end
    end

    // Sine magnitude lookup, stage 3
    mrm_sine_rom u_sine_rom (
        .aclk    (aclk),
        .rd_en   (ld3),
        .rd_addr (s2_addr_reg),
        .rd_data (rom_data)
    );

    always_ff @(posedge aclk) begin
        if (ld3) begin
            s3_neg_reg     <= s2_neg_reg;
            s3_pass_reg    <= s2_pass_reg;
            s3_abs_reg     <= s2_abs_reg;
            s3_sample_reg  <= s2_sample_reg;
            s3_prior_reg   <= s2_prior_reg;
            s3_replace_reg <= s2_replace_reg;
        end
    end

    // Multiply magnitudes, stage 4
    always_ff @(posedge aclk) begin
        if (ld4) begin
            s4_prod_reg    <= PROD_W'(s3_abs_reg) * PROD_W'(rom_data);
            s4_neg_reg     <= s3_neg_reg;
            s4_pass_reg    <= s3_pass_reg;
            s4_sample_reg  <= s3_sample_reg;
            s4_prior_reg   <= s3_prior_reg;
            s4_replace_reg <= s3_replace_reg;
        end
    end

    // Round half away from zero, sign, add base and saturate, or pass the sample through
    always_comb begin
        max_s   = SUM_W'((1 << (SAMPLE_BITS - 1)) - 1);
        min_s   = -max_s - SUM_W'(1);
        rounded = {1'b0, s4_prod_reg} + (PROD_W + 1)'(1 << 22);
        mag     = rounded[23 +: SAMPLE_BITS + 1];
        prod_s  = s4_neg_reg ? -$signed({1'b0, mag}) : $signed({1'b0, mag});
        base_s  = s4_replace_reg ? '0 : SUM_W'(s4_prior_reg);
        sum_s   = base_s + prod_s;
        if (s4_pass_reg) begin
            out_next = s4_sample_reg;
        end else if (sum_s > max_s) begin
            out_next = max_s[SAMPLE_BITS-1:0];
        end else if (sum_s < min_s) begin
            out_next = min_s[SAMPLE_BITS-1:0];
        end else begin
            out_next = sum_s[SAMPLE_BITS-1:0];
        end
    end

    // Output register
    always_ff @(posedge aclk) begin
        if (ld_out) begin
            m_sample_reg <= out_next;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = M_TDATA_W'(m_sample_reg);

    // Checks
    `MRM_ASSERT_NEXT(a_phase_hold, !s1_leave, $stable(phase_reg),
        "phase changed with no item leaving the input register")
    `MRM_ASSERT_NEXT(a_clear_all, s1_leave && (s1_op_reg == OP_CLEAR_ALL), phase_reg == '0,
        "clear-all left a phase non-zero")
    `MRM_ASSERT_SAME(a_result_source, $rose(m_tvalid), $past(s4_valid_reg),
        "result appeared without a product stage item")
    `MRM_ASSERT_SAME(a_sine_bound, s3_valid_reg, rom_data <= SINE_W'(ONE_Q23),
        "sine magnitude above one")

endmodule
